// File: rtl/core/usts_pkg.sv
// usts_pkg: shared types and constants for the unordered set table unit
// no dependencies; used by usts_ctrl, usts_dpath and unordered_set_table_unit
`timescale 1ns / 1ps

package usts_pkg;

   // fixed field widths of the item ports
   localparam int CMD_W   = 2;
   localparam int KEY_W   = 32;
   localparam int COUNT_W = 9;

   // defaults for the top-level parameters
   localparam int DEF_CAPACITY  = 256;
   localparam int DEF_KEY_WIDTH = 32;

   // operation codes carried in req_cmd
   typedef enum logic [CMD_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // controller to datapath commands
   typedef struct packed {
      logic start;       // latch item, reset scan pointer
      logic scan_step;   // issue next read and compare
      logic found;       // record hit, aim pointer past the matching entry
      logic shift_step;  // move one entry down
      logic append;      // write key at the end, count up
      logic set_drop;    // flag add refused on full table
      logic clear_cnt;   // empty the table
      logic dec;         // count down after a remove
      logic rsp_load;    // load the result register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      op_type op;
      logic   hit;
      logic   match;
      logic   sweep_done;
      logic   full;
      logic   out_free;
   } status_type;

endpackage

// File: rtl/core/usts_ctrl.sv
// usts_ctrl: sequencing state machine for the unordered set table unit
// depends on usts_pkg; drives commands into usts_dpath
`timescale 1ns / 1ps

module usts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  usts_pkg::status_type   st,
   output usts_pkg::cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_EXEC  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // one item in flight at a time
   assign req_stall = (state_ff != S_IDLE);

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (st.match) begin
               cmd.found = 1'b1;
               state_in  = S_EXEC;
            end else if (st.sweep_done) begin
               state_in = S_EXEC;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            unique case (st.op)
               usts_pkg::OP_ADD: begin
                  if (!st.hit) begin
                     if (st.full) begin
                        cmd.set_drop = 1'b1;
                     end else begin
                        cmd.append = 1'b1;
                     end
                  end
               end
               usts_pkg::OP_REMOVE: begin
                  if (st.hit) begin
                     state_in = S_SHIFT;
                  end
               end
               usts_pkg::OP_CLEAR: begin
                  cmd.clear_cnt = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_SHIFT: begin
            if (st.sweep_done) begin
               cmd.dec  = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_RESP: begin
            if (st.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // an accepted item always starts a scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_SCAN))
      else $error("accepted item did not start a scan");

   // shifting only follows a remove that found its key
   a_shift_remove: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (st.op == usts_pkg::OP_REMOVE && st.hit))
      else $error("shift without a successful remove");

endmodule

// File: rtl/core/usts_dpath.sv
// usts_dpath: entry memory, live count, scan pointer and result register
// depends on usts_pkg; controlled by usts_ctrl
`timescale 1ns / 1ps

module usts_dpath #(
   parameter int CAPACITY  = usts_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = usts_pkg::DEF_KEY_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [usts_pkg::CMD_W-1:0]    req_cmd,
   input  logic [usts_pkg::KEY_W-1:0]    req_key,
   input  usts_pkg::cmd_type             cmd,
   output usts_pkg::status_type          st,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_full_drop,
   output logic [usts_pkg::COUNT_W-1:0]  rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [KEY_WIDTH-1:0] mem [CAPACITY];

   usts_pkg::op_type     op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 hit_ff, hit_in;
   logic                 drop_ff, drop_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic                 pend_ff, pend_in;
   logic [CW-1:0]        pidx_ff, pidx_in;
   logic [KEY_WIDTH-1:0] rdata_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic                 rsp_drop_ff;
   logic [usts_pkg::COUNT_W-1:0] rsp_count_ff;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;

   // memory port control
   always_comb begin
      rd_en   = (cmd.scan_step || cmd.shift_step) && (ptr_ff < count_ff);
      rd_addr = AW'(ptr_ff);
      wr_en   = cmd.append || (cmd.shift_step && pend_ff);
      wr_addr = cmd.append ? AW'(count_ff) : AW'(pidx_ff - CW'(1));
      wr_data = cmd.append ? key_ff : rdata_ff;
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // item, pointer and count next values
   always_comb begin
      op_in    = op_ff;
      key_in   = key_ff;
      hit_in   = hit_ff;
      drop_in  = drop_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      pend_in  = pend_ff;
      pidx_in  = pidx_ff;
      if (cmd.start) begin
         op_in   = usts_pkg::op_type'(req_cmd);
         key_in  = KEY_WIDTH'(req_key);
         hit_in  = 1'b0;
         drop_in = 1'b0;
         ptr_in  = '0;
         pend_in = 1'b0;
      end
      if (cmd.found) begin
         hit_in  = 1'b1;
         ptr_in  = pidx_ff + CW'(1);
         pend_in = 1'b0;
      end
      if (cmd.scan_step || cmd.shift_step) begin
         pend_in = rd_en;
      end
      if (rd_en) begin
         pidx_in = ptr_ff;
         ptr_in  = ptr_ff + CW'(1);
      end
      if (cmd.set_drop) begin
         drop_in = 1'b1;
      end
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.clear_cnt) begin
         count_in = '0;
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      hit_ff  <= hit_in;
      drop_ff <= drop_in;
      ptr_ff  <= ptr_in;
      pidx_ff <= pidx_in;
      if (cmd.rsp_load) begin
         rsp_hit_ff   <= hit_ff;
         rsp_drop_ff  <= drop_ff;
         rsp_count_ff <= usts_pkg::COUNT_W'(count_ff);
      end
   end

   // status back to the controller
   always_comb begin
      st.op         = op_ff;
      st.hit        = hit_ff;
      st.match      = pend_ff && (rdata_ff == key_ff);
      st.sweep_done = !pend_ff && (ptr_ff >= count_ff);
      st.full       = (count_ff == CW'(CAPACITY));
      st.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_full_drop = rsp_drop_ff;
   assign rsp_count     = rsp_count_ff;

   // live count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("live count above capacity");

   // an append grows the count by exactly one
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      cmd.append |=> (count_ff == CW'($past(count_ff) + CW'(1))))
      else $error("append did not grow count by one");

   // a shift write never targets below the first entry
   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift_step && pend_ff) |-> (pidx_ff != '0))
      else $error("shift write below entry zero");

endmodule

// File: rtl/core/unordered_set_table_unit.sv
// unordered_set_table_unit: top level joining usts_ctrl and usts_dpath; depends on usts_pkg
// An item scans the live keys up to a match or the end; a remove that hits then adds the
// move-down pass. One item at a time: the next item is accepted the cycle after the result
// is loaded, and a stalled full result register holds it off. Synchronous reset clears the
// live count and result valid; entries are kept.
`timescale 1ns / 1ps

module unordered_set_table_unit #(
   parameter int CAPACITY  = usts_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = usts_pkg::DEF_KEY_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [usts_pkg::CMD_W-1:0]    req_cmd,
   input  logic [usts_pkg::KEY_W-1:0]    req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_full_drop,
   output logic [usts_pkg::COUNT_W-1:0]  rsp_count
);

   usts_pkg::cmd_type    cmd;
   usts_pkg::status_type st;

   // sequencer
   usts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // storage and compare datapath
   usts_dpath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_cmd),
      .req_key       (req_key),
      .cmd           (cmd),
      .st            (st),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_full_drop (rsp_full_drop),
      .rsp_count     (rsp_count)
   );

endmodule
